// ===== design/dsag_pkg.sv =====
`default_nettype none
package dsag_pkg;

  localparam int MAX_GRID_COLS   = 64;
  localparam int MAX_GRID_ROWS   = 64;
  localparam int COORD_BITS      = 12;
  localparam int NEIGHBOUR_REACH = 2;

  localparam int CELL_COUNT = MAX_GRID_COLS * MAX_GRID_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int GX_W       = $clog2(MAX_GRID_COLS);
  localparam int GY_W       = $clog2(MAX_GRID_ROWS);
  localparam int ENTRY_W    = 2 * COORD_BITS + 1;

  localparam int PT_W      = 13;
  localparam int CMD_W     = 2;
  localparam int COUNT_W   = 13;
  localparam int COUNT_MAX = 8191;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int DIST_W    = 24;
  localparam int INV_W     = 24;
  localparam int IMG_W     = 12;
  localparam int GDIM_W    = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Q16 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd5;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEST        = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST_INSERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT      = 2'd3;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [GY_W-1:0] gy,
                                                   input logic [GX_W-1:0] gx);
    cell_addr = ADDR_W'(gy) * ADDR_W'(MAX_GRID_COLS) + ADDR_W'(gx);
  endfunction

endpackage
`default_nettype wire

// ===== design/disk_sampling_acceptance_grid_top.sv =====
// Acceptance grid for Poisson-disk sampling, one stored point per grid cell.
// Input channel (in_valid / in_stall): a command and a candidate point.
//   clear wipes the grid, test checks the 5x5 cell neighbourhood, test and
//   insert also stores an accepted point, insert stores any point inside the image.
// Result channel (out_valid / out_stall): one word per input word with the
//   accept flag, the inside-image flag and the stored point count.
// Configuration (cfg_we / cfg_index / cfg_data): write only, while idle.
// One item at a time: a sequencer drives a single 12x24 multiplier and the
//   single-port grid memory. A test is accepted, maps the point to its cell
//   (x, then y, then the clamped window), reads each neighbour cell and, when
//   occupied, squares dx and dy and compares (up to 25 cells), then looks up
//   the target cell, stores on an insert and hands off; the result shows in
//   the same cycle that in_stall drops. A point outside the image goes straight
//   from acceptance to hand-off. A scan stops at the first close neighbour.
// Clear walks the 4096-entry memory one entry per cycle.
// After reset the same clearing pass runs before in_stall drops;
//   configuration writes are taken during it.
// The result sits in an output register; a stalled result holds and the
//   next input word is still taken, its result waits until the old one goes.
`default_nettype none
module disk_sampling_acceptance_grid_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dsag_pkg::CMD_W-1:0]     in_command,
  input  wire logic signed [dsag_pkg::PT_W-1:0] in_point_x,
  input  wire logic signed [dsag_pkg::PT_W-1:0] in_point_y,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_accepted,
  output logic                                out_inside_image,
  output logic [dsag_pkg::COUNT_W-1:0]        out_stored_count,
  input  wire logic                           cfg_we,
  input  wire logic [dsag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsag_pkg::CFG_W-1:0]     cfg_data
);
  import dsag_pkg::*;

  localparam int MP_W  = COORD_BITS + INV_W;
  localparam int RAW_W = MP_W - 16;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int D2_W  = SQ_W + 1;
  localparam int WX_W  = GX_W + 4;
  localparam int WY_W  = GY_W + 4;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_MX   = 4'd2;
  localparam logic [3:0] ST_MY   = 4'd3;
  localparam logic [3:0] ST_WIN  = 4'd4;
  localparam logic [3:0] ST_RD   = 4'd5;
  localparam logic [3:0] ST_DX   = 4'd6;
  localparam logic [3:0] ST_DY   = 4'd7;
  localparam logic [3:0] ST_CMP  = 4'd8;
  localparam logic [3:0] ST_INS  = 4'd9;
  localparam logic [3:0] ST_WR   = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  // control state
  logic [3:0]          state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                clr_cmd_r, clr_cmd_nxt;

  // configuration
  logic [DIST_W-1:0]   min_dist_sq_r;
  logic [INV_W-1:0]    inv_cell_q16_r;
  logic [IMG_W-1:0]    image_width_r;
  logic [IMG_W-1:0]    image_height_r;
  logic [GDIM_W-1:0]   grid_cols_r;
  logic [GDIM_W-1:0]   grid_rows_r;

  // item payload
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [GX_W-1:0]       gx_r, gx_nxt, x0_r, x0_nxt, x1_r, x1_nxt, cx_r, cx_nxt;
  logic [GY_W-1:0]       gy_r, gy_nxt, y0_r, y0_nxt, y1_r, y1_nxt, cy_r, cy_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt, prod_r, prod_nxt;
  logic                  acc_r, acc_nxt, inside_r, inside_nxt;
  logic                  out_acc_r, out_acc_nxt, out_inside_r, out_inside_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  // grid memory
  logic [ENTRY_W-1:0] mem [CELL_COUNT];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_we, mem_re;

  // shared multiplier
  logic [COORD_BITS-1:0] mul_a;
  logic [INV_W-1:0]      mul_b;
  logic [MP_W-1:0]       mul_p;
  logic [RAW_W-1:0]      mul_raw;

  logic                  in_inside;
  logic                  do_ins;
  logic [GX_W-1:0]       cols_m1;
  logic [GY_W-1:0]       rows_m1;
  logic                  ent_valid;
  logic [COORD_BITS-1:0] ent_x, ent_y;
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] adx, ady;
  logic [D2_W-1:0]       d2;
  logic [WX_W-1:0]       wx_c, wx_hi;
  logic [WY_W-1:0]       wy_c, wy_hi;
  logic                  last_cell;
  logic [3:0]            adv_state;
  logic [GX_W-1:0]       adv_cx;
  logic [GY_W-1:0]       adv_cy;

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_inside_image = out_inside_r;
  assign out_stored_count = out_count_r;

  assign in_inside = !in_point_x[PT_W-1] && !in_point_y[PT_W-1] &&
                     (in_point_x[COORD_BITS-1:0] < image_width_r) &&
                     (in_point_y[COORD_BITS-1:0] < image_height_r);
  assign do_ins    = (cmd_r == CMD_INSERT) || ((cmd_r == CMD_TEST_INSERT) && acc_r);

  // used grid size, zero acts as one and large values saturate
  always_comb begin
    if (grid_cols_r == '0) begin
      cols_m1 = '0;
    end else if (32'(grid_cols_r) > MAX_GRID_COLS) begin
      cols_m1 = GX_W'(MAX_GRID_COLS - 1);
    end else begin
      cols_m1 = GX_W'(grid_cols_r - GDIM_W'(1));
    end
    if (grid_rows_r == '0) begin
      rows_m1 = '0;
    end else if (32'(grid_rows_r) > MAX_GRID_ROWS) begin
      rows_m1 = GY_W'(MAX_GRID_ROWS - 1);
    end else begin
      rows_m1 = GY_W'(grid_rows_r - GDIM_W'(1));
    end
  end

  assign ent_valid = rd_data_r[ENTRY_W-1];
  assign ent_x     = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign ent_y     = rd_data_r[COORD_BITS-1:0];
  assign dx        = {1'b0, ent_x} - {1'b0, px_r};
  assign dy        = {1'b0, ent_y} - {1'b0, py_r};
  assign adx       = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ady       = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign d2        = D2_W'(sq_r) + D2_W'(prod_r);

  always_comb begin
    case (state_r)
      ST_MX: begin
        mul_a = px_r;
        mul_b = inv_cell_q16_r;
      end
      ST_MY: begin
        mul_a = py_r;
        mul_b = inv_cell_q16_r;
      end
      ST_DX: begin
        mul_a = adx;
        mul_b = INV_W'(adx);
      end
      default: begin
        mul_a = ady;
        mul_b = INV_W'(ady);
      end
    endcase
  end

  assign mul_p   = MP_W'(mul_a) * MP_W'(mul_b);
  assign mul_raw = mul_p[MP_W-1:16];

  // clamped window around the point's cell
  assign wx_c  = WX_W'(gx_r);
  assign wy_c  = WY_W'(gy_r);
  assign wx_hi = wx_c + WX_W'(NEIGHBOUR_REACH);
  assign wy_hi = wy_c + WY_W'(NEIGHBOUR_REACH);

  // step to the next neighbour cell in row order
  assign last_cell = (cx_r == x1_r) && (cy_r == y1_r);
  always_comb begin
    adv_cx    = cx_r;
    adv_cy    = cy_r;
    adv_state = ST_RD;
    if (last_cell) begin
      adv_state = ST_INS;
    end else if (cx_r == x1_r) begin
      adv_cx = x0_r;
      adv_cy = cy_r + GY_W'(1);
    end else begin
      adv_cx = cx_r + GX_W'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cell_addr(gy_r, gx_r);
    mem_wdata = {1'b1, px_r, py_r};
    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_RD: begin
        mem_re   = 1'b1;
        mem_addr = cell_addr(cy_r, cx_r);
      end
      ST_INS: begin
        mem_re = do_ins;
      end
      ST_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_cmd_nxt    = clr_cmd_r;
    cmd_nxt        = cmd_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    gx_nxt         = gx_r;
    gy_nxt         = gy_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    sq_nxt         = sq_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    inside_nxt     = inside_r;
    out_acc_nxt    = out_acc_r;
    out_inside_nxt = out_inside_r;
    out_count_nxt  = out_count_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;
          px_nxt  = in_point_x[COORD_BITS-1:0];
          py_nxt  = in_point_y[COORD_BITS-1:0];
          acc_nxt = 1'b0;
          if (in_command == CMD_CLEAR) begin
            count_nxt   = '0;
            inside_nxt  = 1'b0;
            clr_cnt_nxt = '0;
            clr_cmd_nxt = 1'b1;
            state_nxt   = ST_CLR;
          end else begin
            inside_nxt = in_inside;
            state_nxt  = in_inside ? ST_MX : ST_DONE;
          end
        end
      end
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_MX: begin
        gx_nxt    = (mul_raw > RAW_W'(cols_m1)) ? cols_m1 : mul_raw[GX_W-1:0];
        state_nxt = ST_MY;
      end
      ST_MY: begin
        gy_nxt    = (mul_raw > RAW_W'(rows_m1)) ? rows_m1 : mul_raw[GY_W-1:0];
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        x0_nxt    = (wx_c >= WX_W'(NEIGHBOUR_REACH)) ?
                    GX_W'(wx_c - WX_W'(NEIGHBOUR_REACH)) : '0;
        y0_nxt    = (wy_c >= WY_W'(NEIGHBOUR_REACH)) ?
                    GY_W'(wy_c - WY_W'(NEIGHBOUR_REACH)) : '0;
        x1_nxt    = (wx_hi > WX_W'(cols_m1)) ? cols_m1 : GX_W'(wx_hi);
        y1_nxt    = (wy_hi > WY_W'(rows_m1)) ? rows_m1 : GY_W'(wy_hi);
        cx_nxt    = x0_nxt;
        cy_nxt    = y0_nxt;
        acc_nxt   = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_DX;
      end
      ST_DX: begin
        if (ent_valid) begin
          sq_nxt    = mul_p[SQ_W-1:0];
          state_nxt = ST_DY;
        end else begin
          cx_nxt    = adv_cx;
          cy_nxt    = adv_cy;
          state_nxt = adv_state;
        end
      end
      ST_DY: begin
        prod_nxt  = mul_p[SQ_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (d2 < D2_W'(min_dist_sq_r)) begin
          // a close neighbour settles it, stop scanning
          acc_nxt   = 1'b0;
          state_nxt = ST_INS;
        end else begin
          cx_nxt    = adv_cx;
          cy_nxt    = adv_cy;
          state_nxt = adv_state;
        end
      end
      ST_INS: begin
        state_nxt = do_ins ? ST_WR : ST_DONE;
      end
      ST_WR: begin
        // overwrite of an occupied cell keeps the count
        if (!ent_valid && (count_r < COUNT_W'(COUNT_MAX))) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_acc_nxt    = acc_r;
          out_inside_nxt = inside_r;
          out_count_nxt  = count_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      clr_cnt_r      <= '0;
      clr_cmd_r      <= 1'b0;
      min_dist_sq_r  <= DIST_W'(100);
      inv_cell_q16_r <= INV_W'(9268);
      image_width_r  <= IMG_W'(640);
      image_height_r <= IMG_W'(480);
      grid_cols_r    <= GDIM_W'(64);
      grid_rows_r    <= GDIM_W'(64);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_DIST_SQ:  min_dist_sq_r  <= cfg_data[DIST_W-1:0];
          REG_INV_CELL_Q16: inv_cell_q16_r <= cfg_data[INV_W-1:0];
          REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[IMG_W-1:0];
          REG_IMAGE_HEIGHT: image_height_r <= cfg_data[IMG_W-1:0];
          REG_GRID_COLS:    grid_cols_r    <= cfg_data[GDIM_W-1:0];
          REG_GRID_ROWS:    grid_rows_r    <= cfg_data[GDIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    gx_r         <= gx_nxt;
    gy_r         <= gy_nxt;
    x0_r         <= x0_nxt;
    x1_r         <= x1_nxt;
    y0_r         <= y0_nxt;
    y1_r         <= y1_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    sq_r         <= sq_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    inside_r     <= inside_nxt;
    out_acc_r    <= out_acc_nxt;
    out_inside_r <= out_inside_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

endmodule
`default_nettype wire
